>>> rtl/core/cca_pkg.sv
// Shared types and constants of the cluster chain allocator.
package cca_pkg;

    localparam int CLUSTERS  = 64;
    localparam int CLUSTER_W = 6;
    localparam int LINK_W    = 7;
    localparam int COUNT_W   = 7;
    localparam int SIZE_W    = 16;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_WALK  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_FREE_START = 2'd2
    } status_t;

    // Source of the cluster field of a result
    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_CURSOR = 2'd1,
        SRC_ALLOC  = 2'd2
    } src_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CHECK     = 3'd1,
        ST_ALLOC     = 3'd2,
        ST_WALK      = 3'd3,
        ST_WALK_WAIT = 3'd4,
        ST_REPORT    = 3'd5
    } state_t;

    typedef struct packed {
        logic    load;
        logic    alloc_step;
        logic    walk_step;
        logic    emit;
        logic    emit_last;
        status_t emit_status;
        src_t    emit_src;
    } cmd_t;

    typedef struct packed {
        logic op_walk;
        logic alloc_fits;
        logic start_free;
        logic alloc_last;
        logic walk_end;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/cluster_chain_allocator.sv
// Top level of the cluster chain allocator: controller plus datapath.
//
//  Channel   Direction  Ports                                       Moves
//  s_        in         s_valid s_ready s_op s_size_bytes           one request per transfer
//                       s_start_cluster
//  m_        out        m_valid m_ready m_cluster m_last m_status   one cluster per transfer
//
// Sequence: a request passes through the capacity/free check state after its transfer.
//   An allocate then emits one cluster per cycle while the result register is free.
//   A walk emits a cluster, then passes a wait state as the link memory read is registered;
//   an error result is emitted from the report state that follows the check.
// Reset: clears the allocation pointer and the result valid flag, so every cluster
//   is free again at once; the link memory is not cleared, it is always written
//   before it is read.
// Stalls: the result register holds while m_ready is low and the sequence waits;
//   a new request is taken once the last result of the previous one is loaded.
module cluster_chain_allocator #(
    parameter int CLUSTER_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_size_bytes,
    input  logic [5:0]  s_start_cluster,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_cluster,
    output logic        m_last,
    output logic [1:0]  m_status
);

    cca_pkg::cmd_t cmd;
    cca_pkg::sts_t sts;

    // Sequence the request: accept, check, then step clusters into the result register
    cca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the allocation pointer, link memory and result register
    cca_dp #(
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_op            (s_op),
        .s_size_bytes    (s_size_bytes),
        .s_start_cluster (s_start_cluster),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cluster       (m_cluster),
        .m_last          (m_last),
        .m_status        (m_status)
    );

endmodule

>>> rtl/core/cca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/cca_ctrl.sv
// Controller state machine of the cluster chain allocator.
module cca_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cca_pkg::sts_t sts,
    output cca_pkg::cmd_t cmd
);

    cca_pkg::state_t state_reg;
    cca_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cca_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            cca_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = cca_pkg::ST_CHECK;
                end
            end
            cca_pkg::ST_CHECK: begin
                if (sts.op_walk) begin
                    state_next = sts.start_free ? cca_pkg::ST_REPORT : cca_pkg::ST_WALK;
                end else begin
                    state_next = sts.alloc_fits ? cca_pkg::ST_ALLOC : cca_pkg::ST_REPORT;
                end
            end
            cca_pkg::ST_ALLOC: begin
                if (sts.out_free) begin
                    cmd.alloc_step  = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = sts.alloc_last;
                    cmd.emit_status = cca_pkg::STATUS_OK;
                    cmd.emit_src    = cca_pkg::SRC_ALLOC;
                    if (sts.alloc_last) begin
                        state_next = cca_pkg::ST_IDLE;
                    end
                end
            end
            cca_pkg::ST_WALK: begin
                if (sts.out_free) begin
                    cmd.walk_step   = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = sts.walk_end;
                    cmd.emit_status = cca_pkg::STATUS_OK;
                    cmd.emit_src    = cca_pkg::SRC_CURSOR;
                    state_next      = sts.walk_end ? cca_pkg::ST_IDLE : cca_pkg::ST_WALK_WAIT;
                end
            end
            cca_pkg::ST_WALK_WAIT: begin
                state_next = cca_pkg::ST_WALK;
            end
            cca_pkg::ST_REPORT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (sts.op_walk) begin
                        cmd.emit_status = cca_pkg::STATUS_FREE_START;
                        cmd.emit_src    = cca_pkg::SRC_CURSOR;
                    end else begin
                        cmd.emit_status = cca_pkg::STATUS_FULL;
                        cmd.emit_src    = cca_pkg::SRC_ZERO;
                    end
                    state_next = cca_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cca_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/cca_dp.sv
// Datapath: allocation pointer, size and walk registers, link memory, result register.
module cca_dp #(
    parameter int CLUSTER_BYTES = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_op,
    input  logic [cca_pkg::SIZE_W-1:0]      s_size_bytes,
    input  logic [cca_pkg::CLUSTER_W-1:0]   s_start_cluster,
    input  cca_pkg::cmd_t                   cmd,
    output cca_pkg::sts_t                   sts,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cca_pkg::CLUSTER_W-1:0]   m_cluster,
    output logic                            m_last,
    output logic [1:0]                      m_status
);

    localparam int CB_W  = $clog2(CLUSTER_BYTES + 1);
    localparam int CAP_W = cca_pkg::COUNT_W + CB_W;
    localparam int CMP_W = (CAP_W > cca_pkg::SIZE_W) ? CAP_W : cca_pkg::SIZE_W;
    localparam logic [CB_W-1:0] CB = CB_W'(CLUSTER_BYTES);
    localparam logic [cca_pkg::COUNT_W-1:0] ALL_CLUSTERS = cca_pkg::COUNT_W'(cca_pkg::CLUSTERS);
    localparam logic [cca_pkg::COUNT_W-1:0] WALK_MAX = cca_pkg::COUNT_W'(cca_pkg::CLUSTERS - 1);
    localparam logic [cca_pkg::LINK_W-1:0] LINK_END = cca_pkg::LINK_W'(cca_pkg::CLUSTERS);

    // Clusters are taken lowest first and never freed, so the free ones are
    // exactly those at or above the allocation pointer.
    logic [cca_pkg::COUNT_W-1:0]   nf_reg, nf_next;
    logic                          m_valid_reg, m_valid_next;
    cca_pkg::op_t                  op_reg;
    logic [cca_pkg::SIZE_W-1:0]    rem_reg;
    logic [cca_pkg::CLUSTER_W-1:0] cur_reg;
    logic [CAP_W-1:0]              cap_reg;
    logic [cca_pkg::COUNT_W-1:0]   walk_cnt_reg;
    logic [cca_pkg::CLUSTER_W-1:0] cluster_reg;
    logic                          last_reg;
    cca_pkg::status_t              status_reg;

    logic [cca_pkg::COUNT_W-1:0]   free_cnt;
    logic [cca_pkg::LINK_W-1:0]    link_rd;
    logic [cca_pkg::LINK_W-1:0]    link_wr;
    logic [cca_pkg::SIZE_W-1:0]    rem_dec;
    logic [cca_pkg::CLUSTER_W-1:0] emit_cluster;

    assign free_cnt = ALL_CLUSTERS - nf_reg;
    assign rem_dec  = cca_pkg::SIZE_W'(CMP_W'(rem_reg) - CMP_W'(CB));

    assign sts.op_walk    = (op_reg == cca_pkg::OP_WALK);
    assign sts.alloc_fits = (nf_reg != ALL_CLUSTERS) && (CMP_W'(rem_reg) <= CMP_W'(cap_reg));
    assign sts.start_free = (cca_pkg::COUNT_W'(cur_reg) >= nf_reg);
    assign sts.alloc_last = (CMP_W'(rem_reg) <= CMP_W'(CB));
    assign sts.walk_end   = (link_rd >= LINK_END) || (walk_cnt_reg == WALK_MAX);
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign link_wr = sts.alloc_last ? LINK_END : cca_pkg::LINK_W'(nf_reg + 1'b1);

    cca_ram #(
        .WIDTH (cca_pkg::LINK_W),
        .DEPTH (cca_pkg::CLUSTERS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (cmd.alloc_step),
        .wr_addr (nf_reg[cca_pkg::CLUSTER_W-1:0]),
        .wr_data (link_wr),
        .rd_addr (cur_reg),
        .rd_data (link_rd)
    );

    always_comb begin
        unique case (cmd.emit_src)
            cca_pkg::SRC_ZERO:   emit_cluster = '0;
            cca_pkg::SRC_CURSOR: emit_cluster = cur_reg;
            cca_pkg::SRC_ALLOC:  emit_cluster = nf_reg[cca_pkg::CLUSTER_W-1:0];
            default:             emit_cluster = '0;
        endcase
    end

    always_comb begin
        nf_next      = nf_reg;
        m_valid_next = m_valid_reg;
        if (cmd.alloc_step) begin
            nf_next = nf_reg + 1'b1;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nf_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            nf_reg      <= nf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= cca_pkg::op_t'(s_op);
            rem_reg      <= s_size_bytes;
            cur_reg      <= s_start_cluster;
            cap_reg      <= CAP_W'(free_cnt) * CAP_W'(CB);
            walk_cnt_reg <= '0;
        end
        if (cmd.alloc_step) begin
            rem_reg <= rem_dec;
        end
        if (cmd.walk_step) begin
            cur_reg      <= link_rd[cca_pkg::CLUSTER_W-1:0];
            walk_cnt_reg <= walk_cnt_reg + 1'b1;
        end
        if (cmd.emit) begin
            cluster_reg <= emit_cluster;
            last_reg    <= cmd.emit_last;
            status_reg  <= cmd.emit_status;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_cluster = cluster_reg;
    assign m_last    = last_reg;
    assign m_status  = status_reg;

    a_nf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nf_reg <= ALL_CLUSTERS)
        else $error("allocation pointer past last cluster");

    a_alloc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_step |-> (nf_reg < ALL_CLUSTERS))
        else $error("allocation step with no free cluster");

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_nf_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.alloc_step |=> $stable(nf_reg))
        else $error("allocation pointer moved without allocation");

endmodule

>>> test/cca_checker.sv
`timescale 1ns / 100ps
// Checker of the cluster chain allocator: tracks the cluster table and compares every result.
module cca_checker #(
    parameter int CLUSTER_BYTES = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_op,
    input  logic [cca_pkg::SIZE_W-1:0]    s_size_bytes,
    input  logic [cca_pkg::CLUSTER_W-1:0] s_start_cluster,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [cca_pkg::CLUSTER_W-1:0] m_cluster,
    input  logic                          m_last,
    input  logic [1:0]                    m_status,
    output int                            error_count,
    output int                            outstanding
);

    typedef struct packed {
        logic [cca_pkg::CLUSTER_W-1:0] cluster;
        logic                          last;
        cca_pkg::status_t              status;
    } chain_beat_t;

    chain_beat_t                  due_beats[$];
    logic [cca_pkg::LINK_W-1:0]   next_link[cca_pkg::CLUSTERS];
    logic [cca_pkg::CLUSTERS-1:0] cluster_free;
    int                           clusters_free;

    // Append one expected transfer at the tail of the queue.
    task automatic queue_beat(input logic [cca_pkg::CLUSTER_W-1:0] cluster,
                              input logic last, input cca_pkg::status_t status);
        chain_beat_t beat;
        beat.cluster = cluster;
        beat.last    = last;
        beat.status  = status;
        due_beats.insert(due_beats.size(), beat);
    endtask

    // Apply one request to the table copy and queue the clusters it must produce.
    task automatic book_request(input cca_pkg::op_t op,
                                input logic [cca_pkg::SIZE_W-1:0] size,
                                input logic [cca_pkg::CLUSTER_W-1:0] start);
        int                         need;
        int                         got;
        int                         prev;
        int                         cur;
        int                         hops;
        logic [cca_pkg::LINK_W-1:0] nxt;
        logic                       chain_end;

        if (op == cca_pkg::OP_ALLOC) begin
            need = (int'(size) + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
            if (need == 0)
                need = 1;
            if (need > clusters_free) begin
                queue_beat('0, 1'b1, cca_pkg::STATUS_FULL);
            end else begin
                got  = 0;
                prev = 0;
                for (int i = 0; i < cca_pkg::CLUSTERS && got < need; i++) begin
                    if (cluster_free[i]) begin
                        cluster_free[i] = 1'b0;
                        clusters_free--;
                        if (got > 0)
                            next_link[prev] = cca_pkg::LINK_W'(i);
                        next_link[i] = cca_pkg::LINK_W'(cca_pkg::CLUSTERS);
                        queue_beat(cca_pkg::CLUSTER_W'(i), (got + 1 == need),
                                   cca_pkg::STATUS_OK);
                        prev = i;
                        got++;
                    end
                end
            end
        end else if (cluster_free[start]) begin
            queue_beat(start, 1'b1, cca_pkg::STATUS_FREE_START);
        end else begin
            cur       = int'(start);
            hops      = 0;
            chain_end = 1'b0;
            while (!chain_end) begin
                nxt       = next_link[cur];
                chain_end = (int'(nxt) >= cca_pkg::CLUSTERS) || (hops + 1 >= cca_pkg::CLUSTERS);
                queue_beat(cca_pkg::CLUSTER_W'(cur), chain_end, cca_pkg::STATUS_OK);
                hops++;
                cur = int'(nxt);
            end
        end
    endtask

    always @(posedge aclk) begin
        chain_beat_t want;
        if (!aresetn) begin
            cluster_free  = '1;
            clusters_free = cca_pkg::CLUSTERS;
            due_beats.delete();
        end else begin
            if (s_valid && s_ready)
                book_request(cca_pkg::op_t'(s_op), s_size_bytes, s_start_cluster);
            if (m_valid && m_ready) begin
                if (due_beats.size() == 0) begin
                    $error("result with nothing expected: cluster %0d last %0d status %0d",
                           m_cluster, m_last, m_status);
                    error_count++;
                end else begin
                    want = due_beats.pop_front();
                    if (m_cluster !== want.cluster) begin
                        $error("m_cluster mismatch: expected %0d, got %0d",
                               want.cluster, m_cluster);
                        error_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("m_last mismatch: expected %0d, got %0d", want.last, m_last);
                        error_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("m_status mismatch: expected %0d, got %0d",
                               want.status, m_status);
                        error_count++;
                    end
                end
            end
        end
        outstanding = due_beats.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, request and result traffic, and the verdict.
module testbench;

    localparam int CLUSTER_BYTES     = 512;
    localparam int RANDOM_ITEMS      = 210;
    localparam int TAIL_ITEMS        = 30;      // last items run with no idling
    localparam int STALL_AT_ITEM     = 70;      // random item that starts the long hold-off
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES      = 40;
    localparam int CYCLE_LIMIT       = 1_000_000;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_op;
    logic [cca_pkg::SIZE_W-1:0]    s_size_bytes;
    logic [cca_pkg::CLUSTER_W-1:0] s_start_cluster;
    logic                          m_valid;
    logic                          m_ready;
    logic [cca_pkg::CLUSTER_W-1:0] m_cluster;
    logic                          m_last;
    logic [1:0]                    m_status;

    int error_count;
    int outstanding;
    int cycle_count;

    // Handshake flags between the request and result processes.
    bit tail_phase;
    bit stall_request;
    bit stall_served;

    // Free clusters as seen by the stimulus; clusters are never freed, and the
    // lowest free ones go first, so clusters 0 .. CLUSTERS-clusters_left-1 are in use.
    int clusters_left = cca_pkg::CLUSTERS;

    cluster_chain_allocator #(
        .CLUSTER_BYTES(CLUSTER_BYTES)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_size_bytes   (s_size_bytes),
        .s_start_cluster(s_start_cluster),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cluster      (m_cluster),
        .m_last         (m_last),
        .m_status       (m_status)
    );

    cca_checker #(
        .CLUSTER_BYTES(CLUSTER_BYTES)
    ) chain_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_size_bytes   (s_size_bytes),
        .s_start_cluster(s_start_cluster),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cluster      (m_cluster),
        .m_last         (m_last),
        .m_status       (m_status),
        .error_count    (error_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    // Stop a hung run at the cycle limit.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one request, hold it until its transfer, then maybe pause.
    // Unless it pauses, leave s_valid high on return so back-to-back requests never drop it.
    task automatic offer_request(input cca_pkg::op_t op,
                                 input logic [cca_pkg::SIZE_W-1:0] size,
                                 input logic [cca_pkg::CLUSTER_W-1:0] start);
        int need;
        s_valid         <= 1'b1;
        s_op            <= op;
        s_size_bytes    <= size;
        s_start_cluster <= start;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (op == cca_pkg::OP_ALLOC) begin
            need = (int'(size) + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
            if (need == 0)
                need = 1;
            if (need <= clusters_left)
                clusters_left -= need;
        end
        // Keep offering without gaps while the long hold-off is pending so the block fills up.
        if (!tail_phase && !(stall_request && !stall_served) && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // Result side: random ready bursts, calm stretches, and one long hold-off.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request && !stall_served) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge aclk);
                stall_served = 1'b1;
                m_ready <= 1'b1;
            end else if (tail_phase) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                // Calm stretch: accept every transfer for a while.
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end else if ($urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Request side and verdict.
    initial begin
        cca_pkg::op_t                  op;
        logic [cca_pkg::SIZE_W-1:0]    size;
        logic [cca_pkg::CLUSTER_W-1:0] start;
        int                            pick;

        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_op            <= cca_pkg::OP_ALLOC;
        s_size_bytes    <= '0;
        s_start_cluster <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        offer_request(cca_pkg::OP_WALK,  16'd0,     6'd0);    // walk on an empty disk: start is free
        offer_request(cca_pkg::OP_WALK,  16'hFFFF,  6'd63);   // highest start, also free
        offer_request(cca_pkg::OP_ALLOC, 16'd0,     6'd63);   // zero length still takes one cluster
        offer_request(cca_pkg::OP_ALLOC, 16'hFFFF,  6'd0);    // needs 128 clusters: report full
        offer_request(cca_pkg::OP_ALLOC, 16'd512,   6'd0);    // exactly one cluster
        offer_request(cca_pkg::OP_ALLOC, 16'd513,   6'd0);    // one byte over: two clusters
        offer_request(cca_pkg::OP_ALLOC, 16'd1,     6'd0);
        offer_request(cca_pkg::OP_ALLOC, 16'd10240, 6'd0);    // 20-cluster chain
        offer_request(cca_pkg::OP_WALK,  16'd0,     6'd0);    // single-cluster chain
        offer_request(cca_pkg::OP_WALK,  16'd0,     6'd2);    // two-cluster chain
        offer_request(cca_pkg::OP_WALK,  16'hFFFF,  6'd5);    // long chain from its head
        offer_request(cca_pkg::OP_WALK,  16'd0,     6'd14);   // enter mid-chain
        offer_request(cca_pkg::OP_WALK,  16'd0,     6'd24);   // chain tail alone
        offer_request(cca_pkg::OP_WALK,  16'd0,     6'd25);   // first free cluster
        offer_request(cca_pkg::OP_ALLOC, 16'd32768, 6'd0);    // 64 clusters, too few left
        offer_request(cca_pkg::OP_ALLOC, 16'd511,   6'd0);
        offer_request(cca_pkg::OP_WALK,  16'd0,     6'd63);

        // Random part: mostly walks over the chains built so far, some allocations.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == STALL_AT_ITEM)
                stall_request = 1'b1;
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            op    = cca_pkg::OP_WALK;
            size  = cca_pkg::SIZE_W'($urandom);
            start = cca_pkg::CLUSTER_W'($urandom);
            pick  = $urandom_range(0, 99);
            if (pick < 25) begin
                op   = cca_pkg::OP_ALLOC;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    size = cca_pkg::SIZE_W'($urandom_range(0, 2 * CLUSTER_BYTES));
                else if (pick < 75)
                    size = cca_pkg::SIZE_W'($urandom);
                else if (pick < 90) begin
                    // Fill the disk exactly once it is nearly full.
                    if (clusters_left == 0)
                        size = '0;
                    else if (clusters_left <= 6)
                        size = cca_pkg::SIZE_W'(clusters_left * CLUSTER_BYTES
                                                - $urandom_range(0, CLUSTER_BYTES - 1));
                    else
                        size = cca_pkg::SIZE_W'($urandom_range(0, 4 * CLUSTER_BYTES));
                end else
                    size = cca_pkg::SIZE_W'((clusters_left + 1) * CLUSTER_BYTES);
            end else if (clusters_left < cca_pkg::CLUSTERS && $urandom_range(0, 3) != 0) begin
                // Aim most walks at clusters that are in use.
                start = cca_pkg::CLUSTER_W'($urandom_range(0,
                                                           cca_pkg::CLUSTERS - 1 - clusters_left));
            end
            offer_request(op, size, start);
        end
        s_valid <= 1'b0;

        // Drain: let the checker book the last request, wait for every expected
        // cluster, then watch for strays.
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (error_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
